[rtl/itpa_pkg.sv]
// ----------------------------------------------------------------------------
// itpa_pkg
// Shared types, constants and helpers for the integer to padded ASCII block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itpa_pkg;

    localparam int MAX_PAD     = 63;
    localparam int DIGIT_SLOTS = 24;
    localparam int IDX_W       = $clog2(DIGIT_SLOTS);
    localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);
    // Decimal digit: four steps of sixteen dividend bits each.
    localparam int DEC_STEPS   = 4;
    localparam int STEP_W      = $clog2(DEC_STEPS);
    // ceil(2^23 / 10); exact quotient by ten for any 20-bit partial dividend.
    localparam logic [19:0] DEC_MAGIC = 20'd838861;

    // Radix codes; the unused code falls through to hexadecimal.
    localparam logic [1:0] BASE_OCT = 2'd0;
    localparam logic [1:0] BASE_DEC = 2'd1;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  base_select;
        logic [5:0]  pad_width;
        logic        treat_unsigned;
        logic        zero_pad;
        logic        plus_sign;
        logic        space_sign;
        logic        upper_digits;
    } in_item_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } out_item_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic conv_step;
        logic prep;
        logic emit_sign;
        logic emit_pad;
        logic emit_digit;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic conv_done;
        logic has_sign;
        logic pad_zero;
        logic idx_zero;
        logic slot_free;
    } sts_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base_ch;
        base_ch = upper ? CH_UPPER_A : CH_LOWER_A;
        if (d < 4'd10)
            digit_char = CH_ZERO + {4'd0, d};
        else
            digit_char = base_ch + {4'd0, d} - 8'd10;
    endfunction

endpackage

`default_nettype wire

[rtl/itpa_dp.sv]
// ----------------------------------------------------------------------------
// itpa_dp
// Datapath: operand registers, digit extraction, digit buffer, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itpa_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  itpa_pkg::in_item_t      in_data,
    input  itpa_pkg::cmd_t          cmd,
    output itpa_pkg::sts_t          sts,
    input  wire logic               out_stall,
    output logic                    out_valid,
    output itpa_pkg::out_item_t     out_data
);

    logic [63:0]                  num_reg, num_next;
    logic [3:0]                   rem_reg, rem_next;
    logic [itpa_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [itpa_pkg::CNT_W-1:0]   ndig_reg, ndig_next;
    logic [itpa_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [5:0]                   pad_reg, pad_next;
    logic [5:0]                   pad_cnt_reg, pad_cnt_next;
    logic [1:0]                   base_reg, base_next;
    logic                         zpad_reg, zpad_next;
    logic                         upper_reg, upper_next;
    logic                         has_sign_reg, has_sign_next;
    logic [7:0]                   sign_ch_reg, sign_ch_next;
    logic [3:0]                   buf_reg [itpa_pkg::DIGIT_SLOTS];
    logic                         out_valid_reg, out_valid_next;
    itpa_pkg::out_item_t          out_data_reg, out_data_next;

    logic        neg;
    logic [19:0] dec_x;
    logic [39:0] dec_prod;
    logic [15:0] dec_q;
    logic [3:0]  dec_rem;
    logic        digit_wr;
    logic [3:0]  digit_val;
    logic [itpa_pkg::CNT_W-1:0] ndig_eff;
    logic [5:0]  ndig_ext;
    logic [5:0]  pad_sat;

    // Long division by ten, sixteen dividend bits per step: the quotient chunk
    // comes from a reciprocal multiply; remainder restarts at each digit.
    always_comb
    begin
        dec_x    = {((step_reg == '0) ? 4'd0 : rem_reg), num_reg[63:48]};
        dec_prod = {20'd0, dec_x} * {20'd0, itpa_pkg::DEC_MAGIC};
        dec_q    = dec_prod[38:23];
        dec_rem  = 4'(dec_x - ({1'b0, dec_q, 3'b000} + {3'b000, dec_q, 1'b0}));
    end

    always_comb
    begin
        neg      = !in_data.treat_unsigned && in_data.value[63];
        pad_sat  = (in_data.pad_width > 6'(itpa_pkg::MAX_PAD)) ?
                   6'(itpa_pkg::MAX_PAD) : in_data.pad_width;
        ndig_eff = (ndig_reg == '0) ? itpa_pkg::CNT_W'(1) : ndig_reg;
        ndig_ext = 6'(ndig_eff);

        num_next      = num_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        ndig_next     = ndig_reg;
        idx_next      = idx_reg;
        pad_next      = pad_reg;
        pad_cnt_next  = pad_cnt_reg;
        base_next     = base_reg;
        zpad_next     = zpad_reg;
        upper_next    = upper_reg;
        has_sign_next = has_sign_reg;
        sign_ch_next  = sign_ch_reg;
        digit_wr      = 1'b0;
        digit_val     = 4'd0;

        if (cmd.load)
        begin
            num_next      = neg ? (~in_data.value + 64'd1) : in_data.value;
            step_next     = '0;
            ndig_next     = '0;
            pad_next      = pad_sat;
            base_next     = in_data.base_select;
            zpad_next     = in_data.zero_pad;
            upper_next    = in_data.upper_digits;
            has_sign_next = neg || in_data.plus_sign || in_data.space_sign;
            sign_ch_next  = neg ? itpa_pkg::CH_MINUS :
                            in_data.plus_sign ? itpa_pkg::CH_PLUS : itpa_pkg::CH_SPACE;
        end
        else if (cmd.conv_step)
        begin
            case (base_reg)
                itpa_pkg::BASE_OCT:
                begin
                    digit_wr  = 1'b1;
                    digit_val = {1'b0, num_reg[2:0]};
                    num_next  = num_reg >> 3;
                end
                itpa_pkg::BASE_DEC:
                begin
                    num_next  = {num_reg[47:0], dec_q};
                    rem_next  = dec_rem;
                    step_next = step_reg + itpa_pkg::STEP_W'(1);
                    if (step_reg == itpa_pkg::STEP_W'(itpa_pkg::DEC_STEPS - 1))
                    begin
                        digit_wr  = 1'b1;
                        digit_val = dec_rem;
                    end
                end
                default:
                begin
                    digit_wr  = 1'b1;
                    digit_val = num_reg[3:0];
                    num_next  = num_reg >> 4;
                end
            endcase
            if (digit_wr)
                ndig_next = ndig_reg + itpa_pkg::CNT_W'(1);
        end
        else if (cmd.prep)
        begin
            idx_next     = itpa_pkg::IDX_W'(ndig_eff - itpa_pkg::CNT_W'(1));
            pad_cnt_next = (pad_reg > ndig_ext) ? (pad_reg - ndig_ext) : 6'd0;
        end

        if (cmd.emit_pad)
            pad_cnt_next = pad_cnt_reg - 6'd1;
        if (cmd.emit_digit)
            idx_next = idx_reg - itpa_pkg::IDX_W'(1);
    end

    // Output register: hold while stalled, drop once taken.
    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.emit_sign)
        begin
            out_data_next.character = sign_ch_reg;
            out_data_next.last      = 1'b0;
            out_valid_next          = 1'b1;
        end
        else if (cmd.emit_pad)
        begin
            out_data_next.character = zpad_reg ? itpa_pkg::CH_ZERO : itpa_pkg::CH_SPACE;
            out_data_next.last      = 1'b0;
            out_valid_next          = 1'b1;
        end
        else if (cmd.emit_digit)
        begin
            // A zero value leaves the buffer empty and prints a single '0'.
            out_data_next.character = itpa_pkg::digit_char(
                (ndig_reg == '0) ? 4'd0 : buf_reg[idx_reg], upper_reg);
            out_data_next.last      = (idx_reg == '0);
            out_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        ndig_reg     <= ndig_next;
        idx_reg      <= idx_next;
        pad_reg      <= pad_next;
        pad_cnt_reg  <= pad_cnt_next;
        base_reg     <= base_next;
        zpad_reg     <= zpad_next;
        upper_reg    <= upper_next;
        has_sign_reg <= has_sign_next;
        sign_ch_reg  <= sign_ch_next;
        out_data_reg <= out_data_next;
        if (digit_wr)
            buf_reg[ndig_reg[itpa_pkg::IDX_W-1:0]] <= digit_val;
    end

    always_comb
    begin
        sts.conv_done = (step_reg == '0) &&
                        ((num_reg == 64'd0) ||
                         (ndig_reg == itpa_pkg::CNT_W'(itpa_pkg::DIGIT_SLOTS)));
        sts.has_sign  = has_sign_reg;
        sts.pad_zero  = (pad_cnt_reg == 6'd0);
        sts.idx_zero  = (idx_reg == '0);
        sts.slot_free = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

[rtl/itpa_ctrl.sv]
// ----------------------------------------------------------------------------
// itpa_ctrl
// Controller: sequences load, digit extraction, sign, pad and digit emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itpa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  itpa_pkg::sts_t     sts,
    output itpa_pkg::cmd_t     cmd
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_CONVERT = 5'b00010,
        ST_SIGN    = 5'b00100,
        ST_PAD     = 5'b01000,
        ST_DIGITS  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (sts.conv_done)
                begin
                    cmd.prep   = 1'b1;
                    state_next = ST_SIGN;
                end
                else
                begin
                    cmd.conv_step = 1'b1;
                end
            end
            ST_SIGN:
            begin
                if (!sts.has_sign)
                    state_next = ST_PAD;
                else if (sts.slot_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (sts.pad_zero)
                    state_next = ST_DIGITS;
                else if (sts.slot_free)
                    cmd.emit_pad = 1'b1;
            end
            ST_DIGITS:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (sts.idx_zero)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

[rtl/integer_to_padded_ascii.sv]
// ----------------------------------------------------------------------------
// integer_to_padded_ascii
// Formats one 64-bit number as printf-style ASCII text, one character per item.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one number with its
//   radix, pad width and sign and case flags. An item is accepted on a clock
//   edge with in_valid high and in_stall low. Output channel (out_valid /
//   out_stall / out_data) delivers the optional sign, the pad characters and
//   the digits, most significant first, with last set on the final digit.
//   Sequence: a load, then digit extraction. Octal and hexadecimal extract
//   one digit per step; decimal runs a long division by ten, sixteen
//   dividend bits per cycle, and gets one digit from each pass over the
//   number. The pad count is prepared as extraction ends. Sign, pad and
//   digits then leave at one per cycle while the receiver does not stall,
//   with an idle state between the pad and the digits.
//   One number is worked on at a time: in_stall is high from acceptance until
//   the last character has been loaded into the output register.
//   Reset clears the controller and the output valid; no item is pending.
//   A stalled receiver holds the output register and pauses emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_to_padded_ascii (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  itpa_pkg::in_item_t      in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output itpa_pkg::out_item_t     out_data
);

    itpa_pkg::cmd_t cmd;
    itpa_pkg::sts_t sts;

    // Sequencing of the phases: load, extract digits, sign, pad, digits.
    itpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Operands, digit buffer and the registered output item.
    itpa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[tb/integer_to_padded_ascii_test.sv]
// ----------------------------------------------------------------------------
// integer_to_padded_ascii_test
// Self-checking bench for the integer to padded ASCII formatter: drives
// directed and random numbers through the valid/stall input, predicts the
// printf-style text one character at a time and checks every output item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import itpa_pkg::*;

// Holds the characters still owed by the block, oldest first.
class ascii_scoreboard;
    out_item_t expected_chars[$];
    int        mismatches = 0;

    // Expand one accepted number into the characters it must produce.
    function void note_number(in_item_t num);
        logic [63:0] magnitude;
        logic [63:0] radix;
        logic [3:0]  d;
        logic [7:0]  digit_text[$];
        logic [7:0]  text[$];
        logic [7:0]  letter_a;
        out_item_t   ch;
        bit          negative;
        int          fill;

        negative  = !num.treat_unsigned && num.value[63];
        magnitude = negative ? ~num.value + 64'd1 : num.value;
        letter_a  = num.upper_digits ? CH_UPPER_A : CH_LOWER_A;
        case (num.base_select)
            BASE_OCT: radix = 64'd8;
            BASE_DEC: radix = 64'd10;
            default:  radix = 64'd16;
        endcase

        // Peel digits off the low end, so push each one to the front.
        while (magnitude != 0 && digit_text.size() < DIGIT_SLOTS) begin
            d = 4'(magnitude % radix);
            magnitude = magnitude / radix;
            if (d < 4'd10)
                digit_text.push_front(CH_ZERO + 8'(d));
            else
                digit_text.push_front(letter_a + 8'(d) - 8'd10);
        end
        if (digit_text.size() == 0)
            digit_text.push_back(CH_ZERO);

        if (negative)
            text.push_back(CH_MINUS);
        else if (num.plus_sign)
            text.push_back(CH_PLUS);
        else if (num.space_sign)
            text.push_back(CH_SPACE);

        // Sign sits outside the field width.
        fill = int'(num.pad_width) - digit_text.size();
        while (fill > 0) begin
            text.push_back(num.zero_pad ? CH_ZERO : CH_SPACE);
            fill--;
        end
        foreach (digit_text[i])
            text.push_back(digit_text[i]);

        foreach (text[i]) begin
            ch.character = text[i];
            ch.last      = (i == text.size() - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    // Compare one delivered character against the oldest one owed.
    function void check_char(out_item_t got);
        out_item_t want;

        if (expected_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch: unexpected char 0x%02h last %0b",
                         $realtime, got.character, got.last);
            return;
        end
        want = expected_chars.pop_front();
        if (got.character !== want.character || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch: expected char 0x%02h last %0b, got 0x%02h last %0b",
                         $realtime, want.character, want.last, got.character, got.last);
        end
    endfunction

    function int pending();
        return expected_chars.size();
    endfunction
endclass

module integer_to_padded_ascii_test;

    // Radix codes the package leaves unnamed.
    localparam logic [1:0] RADIX_HEX   = 2'd2;
    localparam logic [1:0] RADIX_SPARE = 2'd3;

    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MOST_NEG  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TEN_POW19 = 64'd10000000000000000000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    // Idle pressure of the current phase, in percent per decision.
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;

    ascii_scoreboard board;

    integer_to_padded_ascii dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // 4 ns period.
    always #2 clk = ~clk;

    // Receiver: stall in random bursts at the phase's rate.
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if ($urandom_range(99) < stall_pct) begin
            out_stall   <= 1'b1;
            hold_cycles <= $urandom_range(0, 8);
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    // Every character that crosses the output handshake gets checked.
    // Signals are sampled as they were just before the edge.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_char(out_data);
    end

    function automatic in_item_t make_number(logic [63:0] value, logic [1:0] base_sel,
                                             logic [5:0] pad, logic uns, logic zpad,
                                             logic plus, logic space, logic upper);
        in_item_t num;
        num.value          = value;
        num.base_select    = base_sel;
        num.pad_width      = pad;
        num.treat_unsigned = uns;
        num.zero_pad       = zpad;
        num.plus_sign      = plus;
        num.space_sign     = space;
        num.upper_digits   = upper;
        return num;
    endfunction

    // Hold the item on the bus until it is taken, then log what it owes.
    // Valid is left high; a random gap drops it for an idle burst.
    task automatic send_number(input in_item_t num);
        in_valid <= 1'b1;
        in_data  <= num;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_number(num);
        if ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // Run limit: far above the slowest legal run (all-decimal, 20 digits,
    // 64 characters each under maximum stall).
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        in_item_t    num;
        logic [63:0] v;
        int          phase_gap[4];
        int          phase_stall[4];

        phase_gap   = '{30, 0, 50, 0};
        phase_stall = '{30, 50, 0, 0};

        board    = new();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        gap_pct   <= 20;
        stall_pct <= 20;

        // Directed: extremes of every field, each radix, each sign rule.
        // zero prints a single digit
        send_number(make_number(64'd0, BASE_DEC, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // longest text: sign, 62 pad zeros and the digit
        send_number(make_number(64'd0, BASE_OCT, 6'd63, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
        send_number(make_number(ALL_ONES, BASE_DEC, 6'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_number(make_number(ALL_ONES, BASE_OCT, 6'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_number(make_number(ALL_ONES, RADIX_HEX, 6'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_number(make_number(ALL_ONES, BASE_DEC, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // sign goes ahead of the pad zeros
        send_number(make_number(ALL_ONES, BASE_DEC, 6'd5, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        // most negative value stays put after negation
        send_number(make_number(MOST_NEG, BASE_DEC, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_number(make_number(MOST_NEG, RADIX_HEX, 6'd30, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_number(make_number(MOST_POS, BASE_DEC, 6'd63, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
        // spare radix code behaves as hexadecimal
        send_number(make_number(64'hDEAD_BEEF_CAFE, RADIX_SPARE, 6'd0, 1'b1, 1'b0, 1'b0,
                                1'b0, 1'b0));
        send_number(make_number(64'hDEAD_BEEF_CAFE, RADIX_SPARE, 6'd20, 1'b1, 1'b1, 1'b0,
                                1'b0, 1'b1));
        // pad narrower than the digits adds nothing
        send_number(make_number(64'd12345, BASE_DEC, 6'd3, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
        send_number(make_number(64'd12345, BASE_DEC, 6'd8, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        // plus wins over space; minus wins over both
        send_number(make_number(64'd12345, BASE_DEC, 6'd8, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        send_number(make_number(-64'd12345, BASE_DEC, 6'd8, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        // unsigned mode still honors plus on a top-bit-set value
        send_number(make_number(MOST_NEG, BASE_DEC, 6'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
        send_number(make_number(64'd255, RADIX_HEX, 6'd2, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_number(make_number(64'd8, BASE_OCT, 6'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_number(make_number(64'd7, BASE_OCT, 6'd63, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_number(make_number(64'd10, BASE_DEC, 6'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_number(make_number(64'hFEDC_BA98_7654_3210, RADIX_HEX, 6'd16, 1'b1, 1'b1,
                                1'b0, 1'b1, 1'b1));

        // Random: four phases of differing pressure; the last one runs clean.
        for (int phase = 0; phase < 4; phase++) begin
            gap_pct   <= phase_gap[phase];
            stall_pct <= phase_stall[phase];
            for (int n = 0; n < 110; n++) begin
                case ($urandom_range(0, 5))
                    0: v = {$urandom, $urandom};
                    1: v = {$urandom, $urandom} >> $urandom_range(1, 63);
                    2: v = 64'($urandom_range(0, 999));
                    3: begin
                        case ($urandom_range(0, 5))
                            0: v = 64'd0;
                            1: v = 64'd1;
                            2: v = ALL_ONES;
                            3: v = MOST_NEG;
                            4: v = MOST_POS;
                            default: v = TEN_POW19;
                        endcase
                    end
                    4: v = ~64'($urandom_range(1, 999)) + 64'd1;
                    default: v = {$urandom, $urandom} | MOST_NEG;
                endcase
                num.value          = v;
                num.base_select    = 2'($urandom_range(0, 3));
                // Mostly short fields, now and then anything up to the max.
                num.pad_width      = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                                 : 6'($urandom_range(0, 24));
                num.treat_unsigned = 1'($urandom_range(0, 1));
                num.zero_pad       = 1'($urandom_range(0, 1));
                num.plus_sign      = 1'($urandom_range(0, 1));
                num.space_sign     = 1'($urandom_range(0, 1));
                num.upper_digits   = 1'($urandom_range(0, 1));
                send_number(num);
            end
        end
        in_valid <= 1'b0;

        // Drain, then linger past one item's worth of output to catch extras.
        while (board.pending() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (board.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/itpa_pkg.sv
rtl/itpa_dp.sv
rtl/itpa_ctrl.sv
rtl/integer_to_padded_ascii.sv
tb/integer_to_padded_ascii_test.sv
